// ----- rtl/core/pid_pkg.sv -----
// shared types, constants and saturation function of the pid step block
`default_nettype none

package pid_pkg;

    localparam int ERR_W   = 32;
    localparam int GAIN_W  = 24;
    localparam int DT_W    = 16;
    localparam int OUT_W   = 48;
    localparam int TERM_W  = 57;
    localparam int SUM_W   = 58;
    localparam int QUO_W   = 49;
    localparam int CNT_W   = 6;

    localparam logic [CNT_W-1:0] DIV_CNT_LAST = CNT_W'(QUO_W - 1);

    localparam logic [1:0] REG_GAIN_PROP  = 2'd0;
    localparam logic [1:0] REG_GAIN_INTEG = 2'd1;
    localparam logic [1:0] REG_GAIN_DERIV = 2'd2;
    localparam logic [1:0] REG_STEP_TIME  = 2'd3;

    localparam logic [DT_W-1:0] STEP_TIME_RST = 16'd655;

    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
    localparam logic [SUM_W-1:0] SUM_MAX = {{(SUM_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {{(SUM_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

    // derivative magnitude limits for positive and negative results
    localparam logic [QUO_W-1:0] DERIV_LIM_POS = {2'b00, {(OUT_W-1){1'b1}}};
    localparam logic [QUO_W-1:0] DERIV_LIM_NEG = {2'b01, {(OUT_W-1){1'b0}}};

    typedef enum logic [2:0] {
        MUL_IDLE,
        MUL_LO,
        MUL_HI,
        MUL_ACC,
        MUL_RND,
        MUL_SGN
    } mul_state_t;

    typedef enum logic [3:0] {
        CTL_IDLE,
        CTL_DIFF,
        CTL_INC,
        CTL_INC_W,
        CTL_PROP,
        CTL_PROP_W,
        CTL_INTEG,
        CTL_INTEG_W,
        CTL_DIV_W,
        CTL_DERIV,
        CTL_DERIV_W,
        CTL_DONE
    } ctl_state_t;

    typedef struct packed {
        logic              start;
        logic              neg;
        logic [GAIN_W-1:0] a;
        logic [OUT_W-1:0]  b;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [TERM_W-1:0] term;
    } mul_rsp_t;

    typedef struct packed {
        logic             start;
        logic [QUO_W-1:0] dividend;
        logic [DT_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [OUT_W-1:0] sat48(input logic [SUM_W-1:0] v);
        logic [OUT_W-1:0] r;
        if ($signed(v) > $signed(SUM_MAX)) begin
            r = OUT_MAX;
        end else if ($signed(v) < $signed(SUM_MIN)) begin
            r = OUT_MIN;
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pid_controller_step_unit.sv -----
// pid step top level: register port, sequencer, state and output register
// ---------------------------------------------------------------------------
// usage
// - s_ channel: one word per control sample, error in signed q16.16
// - m_ channel: one word per sample, saturated drive value in signed q32.16
// - apb port: gains (signed q8.16) at 0x0, 0x4, 0x8, step time at 0xc;
//   write only while no sample is in flight
// - the time from acceptance of a sample to m_tvalid is set by the
//   49-step restoring divider for the derivative; the three products
//   ahead of it run on the shared multiplier while it works, and the
//   derivative product follows it
// - s_tready is high only while the sequencer is idle, so one sample is
//   worked on at a time
// - the result sits in an output register; the next sample is taken while
//   it waits, and the sequencer holds its finished result until the
//   output register is free when m_tready stays low
// - reset clears integral, previous error, gains, and sets the step time
//   to 655 (about 10 ms); m_tvalid drops at once
// ---------------------------------------------------------------------------
`default_nettype none

module pid_controller_step_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // error_sample[31:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata    // drive_value[47:0]
);

    pid_pkg::ctl_state_t state_reg;
    pid_pkg::ctl_state_t state_next;

    logic [pid_pkg::GAIN_W-1:0] gain_prop_reg;
    logic [pid_pkg::GAIN_W-1:0] gain_integ_reg;
    logic [pid_pkg::GAIN_W-1:0] gain_deriv_reg;
    logic [pid_pkg::DT_W-1:0]   step_time_reg;

    logic [pid_pkg::ERR_W-1:0]  err_reg;
    logic [pid_pkg::ERR_W-1:0]  last_reg;
    logic [pid_pkg::ERR_W:0]    diff_reg;
    logic [pid_pkg::OUT_W-1:0]  integ_reg;
    logic [pid_pkg::SUM_W-1:0]  sum_reg;
    logic                       out_valid_reg;
    logic [pid_pkg::OUT_W-1:0]  out_data_reg;

    logic [pid_pkg::ERR_W-1:0]  err_mag;
    logic [pid_pkg::ERR_W:0]    diff_mag;
    logic [pid_pkg::OUT_W-1:0]  integ_mag;
    logic [pid_pkg::GAIN_W-1:0] kp_mag;
    logic [pid_pkg::GAIN_W-1:0] ki_mag;
    logic [pid_pkg::GAIN_W-1:0] kd_mag;
    logic [pid_pkg::QUO_W-1:0]  deriv_lim;
    logic [pid_pkg::OUT_W-1:0]  deriv_mag;
    logic [pid_pkg::SUM_W-1:0]  term_ext;
    logic [pid_pkg::SUM_W-1:0]  integ_ext;
    logic                       cfg_wr;
    logic                       out_free;

    pid_pkg::mul_req_t mul_req;
    pid_pkg::mul_rsp_t mul_rsp;
    pid_pkg::div_req_t div_req;
    pid_pkg::div_rsp_t div_rsp;

    pid_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    pid_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_prop_reg  <= '0;
            gain_integ_reg <= '0;
            gain_deriv_reg <= '0;
            step_time_reg  <= pid_pkg::STEP_TIME_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                pid_pkg::REG_GAIN_PROP:  gain_prop_reg  <= pwdata[pid_pkg::GAIN_W-1:0];
                pid_pkg::REG_GAIN_INTEG: gain_integ_reg <= pwdata[pid_pkg::GAIN_W-1:0];
                pid_pkg::REG_GAIN_DERIV: gain_deriv_reg <= pwdata[pid_pkg::GAIN_W-1:0];
                pid_pkg::REG_STEP_TIME:  step_time_reg  <= pwdata[pid_pkg::DT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            pid_pkg::REG_GAIN_PROP:  prdata = {8'd0, gain_prop_reg};
            pid_pkg::REG_GAIN_INTEG: prdata = {8'd0, gain_integ_reg};
            pid_pkg::REG_GAIN_DERIV: prdata = {8'd0, gain_deriv_reg};
            pid_pkg::REG_STEP_TIME:  prdata = {16'd0, step_time_reg};
            default:                 prdata = '0;
        endcase
    end

    // operand magnitudes
    assign err_mag   = err_reg[pid_pkg::ERR_W-1] ? (32'd0 - err_reg) : err_reg;
    assign diff_mag  = diff_reg[pid_pkg::ERR_W] ? (33'd0 - diff_reg) : diff_reg;
    assign integ_mag = integ_reg[pid_pkg::OUT_W-1] ? (48'd0 - integ_reg) : integ_reg;
    assign kp_mag    = gain_prop_reg[pid_pkg::GAIN_W-1]  ? (24'd0 - gain_prop_reg)  : gain_prop_reg;
    assign ki_mag    = gain_integ_reg[pid_pkg::GAIN_W-1] ? (24'd0 - gain_integ_reg) : gain_integ_reg;
    assign kd_mag    = gain_deriv_reg[pid_pkg::GAIN_W-1] ? (24'd0 - gain_deriv_reg) : gain_deriv_reg;

    // derivative magnitude, saturated, zero for a zero step time
    assign deriv_lim = diff_reg[pid_pkg::ERR_W] ? pid_pkg::DERIV_LIM_NEG : pid_pkg::DERIV_LIM_POS;

    always_comb begin
        priority if (step_time_reg == '0) begin
            deriv_mag = '0;
        end else if (div_rsp.quotient > deriv_lim) begin
            deriv_mag = deriv_lim[pid_pkg::OUT_W-1:0];
        end else begin
            deriv_mag = div_rsp.quotient[pid_pkg::OUT_W-1:0];
        end
    end

    assign term_ext  = {mul_rsp.term[pid_pkg::TERM_W-1], mul_rsp.term};
    assign integ_ext = {{(pid_pkg::SUM_W-pid_pkg::OUT_W){integ_reg[pid_pkg::OUT_W-1]}}, integ_reg};
    assign out_free  = !out_valid_reg || m_tready;

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pid_pkg::CTL_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next       = state_reg;
        mul_req.start    = 1'b0;
        mul_req.neg      = 1'b0;
        mul_req.a        = '0;
        mul_req.b        = '0;
        div_req.start    = 1'b0;
        div_req.dividend = {diff_mag, 1'b0, step_time_reg[pid_pkg::DT_W-1:1]};
        div_req.divisor  = step_time_reg;
        unique case (state_reg)
            pid_pkg::CTL_IDLE: begin
                if (s_tvalid) state_next = pid_pkg::CTL_DIFF;
            end
            pid_pkg::CTL_DIFF: begin
                state_next = pid_pkg::CTL_INC;
            end
            pid_pkg::CTL_INC: begin
                mul_req.start = 1'b1;
                mul_req.neg   = err_reg[pid_pkg::ERR_W-1];
                mul_req.a     = {8'd0, step_time_reg};
                mul_req.b     = {16'd0, err_mag};
                div_req.start = 1'b1;
                state_next    = pid_pkg::CTL_INC_W;
            end
            pid_pkg::CTL_INC_W: begin
                if (mul_rsp.done) state_next = pid_pkg::CTL_PROP;
            end
            pid_pkg::CTL_PROP: begin
                mul_req.start = 1'b1;
                mul_req.neg   = gain_prop_reg[pid_pkg::GAIN_W-1] ^ err_reg[pid_pkg::ERR_W-1];
                mul_req.a     = kp_mag;
                mul_req.b     = {16'd0, err_mag};
                state_next    = pid_pkg::CTL_PROP_W;
            end
            pid_pkg::CTL_PROP_W: begin
                if (mul_rsp.done) state_next = pid_pkg::CTL_INTEG;
            end
            pid_pkg::CTL_INTEG: begin
                mul_req.start = 1'b1;
                mul_req.neg   = gain_integ_reg[pid_pkg::GAIN_W-1] ^ integ_reg[pid_pkg::OUT_W-1];
                mul_req.a     = ki_mag;
                mul_req.b     = integ_mag;
                state_next    = pid_pkg::CTL_INTEG_W;
            end
            pid_pkg::CTL_INTEG_W: begin
                if (mul_rsp.done) state_next = pid_pkg::CTL_DIV_W;
            end
            pid_pkg::CTL_DIV_W: begin
                if (!div_rsp.busy) state_next = pid_pkg::CTL_DERIV;
            end
            pid_pkg::CTL_DERIV: begin
                mul_req.start = 1'b1;
                mul_req.neg   = gain_deriv_reg[pid_pkg::GAIN_W-1] ^ diff_reg[pid_pkg::ERR_W];
                mul_req.a     = kd_mag;
                mul_req.b     = deriv_mag;
                state_next    = pid_pkg::CTL_DERIV_W;
            end
            pid_pkg::CTL_DERIV_W: begin
                if (mul_rsp.done) state_next = pid_pkg::CTL_DONE;
            end
            pid_pkg::CTL_DONE: begin
                if (out_free) state_next = pid_pkg::CTL_IDLE;
            end
            default: begin
                state_next = pid_pkg::CTL_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == pid_pkg::CTL_IDLE);

    // controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg  <= '0;
            integ_reg <= '0;
        end else begin
            if (state_reg == pid_pkg::CTL_DIFF) begin
                last_reg <= err_reg;
            end
            if (state_reg == pid_pkg::CTL_INC_W && mul_rsp.done) begin
                integ_reg <= pid_pkg::sat48(integ_ext + term_ext);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == pid_pkg::CTL_IDLE && s_tvalid) begin
            err_reg <= s_tdata;
        end
        if (state_reg == pid_pkg::CTL_DIFF) begin
            diff_reg <= {err_reg[pid_pkg::ERR_W-1], err_reg}
                      - {last_reg[pid_pkg::ERR_W-1], last_reg};
        end
        if (state_reg == pid_pkg::CTL_INC) begin
            sum_reg <= '0;
        end else if (mul_rsp.done && (state_reg == pid_pkg::CTL_PROP_W
                                   || state_reg == pid_pkg::CTL_INTEG_W
                                   || state_reg == pid_pkg::CTL_DERIV_W)) begin
            sum_reg <= sum_reg + term_ext;
        end
        if (state_reg == pid_pkg::CTL_DONE && out_free) begin
            out_data_reg <= pid_pkg::sat48(sum_reg);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (state_reg == pid_pkg::CTL_DONE && out_free) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/pid_mul.sv -----
// shared multiply unit: 24x48 magnitude product in two passes, rounded and signed
`default_nettype none

module pid_mul (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire pid_pkg::mul_req_t req,
    output pid_pkg::mul_rsp_t      rsp
);

    pid_pkg::mul_state_t state_reg;
    pid_pkg::mul_state_t state_next;

    logic [pid_pkg::GAIN_W-1:0] a_reg;
    logic [pid_pkg::OUT_W-1:0]  b_reg;
    logic                       neg_reg;
    logic [47:0]                pp_reg;
    logic [71:0]                acc_reg;
    logic [71:0]                acc_round;
    logic [55:0]                rnd_reg;
    logic [pid_pkg::TERM_W-1:0] term_reg;
    logic                       done_reg;
    logic [23:0]                b_half;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pid_pkg::MUL_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == pid_pkg::MUL_SGN);
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pid_pkg::MUL_IDLE: if (req.start) state_next = pid_pkg::MUL_LO;
            pid_pkg::MUL_LO:   state_next = pid_pkg::MUL_HI;
            pid_pkg::MUL_HI:   state_next = pid_pkg::MUL_ACC;
            pid_pkg::MUL_ACC:  state_next = pid_pkg::MUL_RND;
            pid_pkg::MUL_RND:  state_next = pid_pkg::MUL_SGN;
            pid_pkg::MUL_SGN:  state_next = pid_pkg::MUL_IDLE;
            default:           state_next = pid_pkg::MUL_IDLE;
        endcase
    end

    // one 24x24 multiplier, low half of b first, then the high half
    assign b_half    = (state_reg == pid_pkg::MUL_LO) ? b_reg[23:0] : b_reg[47:24];
    assign acc_round = acc_reg + 72'h8000;

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            pid_pkg::MUL_IDLE: begin
                if (req.start) begin
                    a_reg   <= req.a;
                    b_reg   <= req.b;
                    neg_reg <= req.neg;
                end
            end
            pid_pkg::MUL_LO: begin
                pp_reg <= a_reg * b_half;
            end
            pid_pkg::MUL_HI: begin
                pp_reg  <= a_reg * b_half;
                acc_reg <= {24'd0, pp_reg};
            end
            pid_pkg::MUL_ACC: begin
                acc_reg <= acc_reg + {pp_reg, 24'd0};
            end
            pid_pkg::MUL_RND: begin
                rnd_reg <= acc_round[71:16];
            end
            pid_pkg::MUL_SGN: begin
                term_reg <= neg_reg ? (57'd0 - {1'b0, rnd_reg}) : {1'b0, rnd_reg};
            end
            default: begin
            end
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.term = term_reg;

endmodule

`default_nettype wire

// ----- rtl/core/pid_div.sv -----
// restoring divider, one quotient bit per cycle, for the derivative term
`default_nettype none

module pid_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire pid_pkg::div_req_t req,
    output pid_pkg::div_rsp_t      rsp
);

    logic                        busy_reg;
    logic [pid_pkg::CNT_W-1:0]   cnt_reg;
    logic [pid_pkg::DT_W-1:0]    divisor_reg;
    logic [pid_pkg::DT_W-1:0]    rem_reg;
    logic [pid_pkg::QUO_W-1:0]   quo_reg;
    logic [pid_pkg::DT_W:0]      trial;
    logic [pid_pkg::DT_W:0]      trial_sub;
    logic                        fits;

    assign trial     = {rem_reg, quo_reg[pid_pkg::QUO_W-1]};
    assign fits      = (trial >= {1'b0, divisor_reg});
    assign trial_sub = trial - {1'b0, divisor_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            if (cnt_reg == pid_pkg::DIV_CNT_LAST) begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            divisor_reg <= req.divisor;
            rem_reg     <= '0;
            quo_reg     <= req.dividend;
        end else if (busy_reg) begin
            rem_reg <= fits ? trial_sub[pid_pkg::DT_W-1:0] : trial[pid_pkg::DT_W-1:0];
            quo_reg <= {quo_reg[pid_pkg::QUO_W-2:0], fits};
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

// ----- rtl/core/pid_checker.sv -----
// port-level checks of the pid step block and their bind to the top level
`default_nettype none

module pid_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        pready,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata
);

    // stalled word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("m_ word changed while stalled");

    // one sample at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second sample taken while busy");

    // a new result only appears as the sequencer goes idle
    a_result_frees_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result loaded without sequencer going idle");

    // reset leaves the block idle with no result
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid && pready)
        else $error("block not idle after reset");

endmodule

bind pid_controller_step_unit pid_checker u_pid_checker (.*);

`default_nettype wire
